>>> rtl/core/bpa_pkg.sv
// shared constants, types and helper functions for the buddy page allocator
// no dependencies
package bpa_pkg;

  localparam int TOP_ORDER = 16;
  localparam int NUM_PAGES = 65536;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int LINK_W    = PAGE_W + 1;
  localparam int ORD_W     = 5;
  localparam int CNT_W     = 17;
  localparam int FREE_W    = 17;
  localparam int NLIST     = TOP_ORDER + 1;
  localparam int LIST_W    = $clog2(NLIST);
  localparam int INFO_W    = ORD_W + 1;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_PAGES);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_ADD_SET, S_ADD_STEP, S_A_SET, S_U_RD, S_U_DO,
    S_A_SPLIT, S_F_SET, S_F_RD, S_F_CHK, S_F_LOOP, S_F_BRD, S_F_BCHK,
    S_I_RD, S_I_CHK, S_I_WR, S_I_LNK, S_FIN_OK, S_FIN_NOBLK, S_FIN_BAD
  } state_t;

  typedef enum logic [3:0] {
    CMD_NOP, CMD_CLR, CMD_LOAD, CMD_ADD_SETUP, CMD_ADD_STEP, CMD_RD, CMD_UNL,
    CMD_INS_WR, CMD_INS_LNK, CMD_ALLOC_SETUP, CMD_SPLIT, CMD_FREE_SETUP,
    CMD_BUD, CMD_MERGE, CMD_FREE_FIN, CMD_FIN
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [1:0] res;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       load_err;
    logic [1:0] op;
    logic       too_big;
    logic       avail;
    logic       rd_head;
    logic       bud_match;
    logic       below_top;
    logic       add_last;
    logic       split_more;
  } stat_t;

  // smallest order whose block holds cnt pages, TOP_ORDER+1 if none
  function automatic logic [ORD_W-1:0] order_for(input logic [CNT_W-1:0] cnt);
    logic [ORD_W-1:0] o;
    o = ORD_W'(TOP_ORDER + 1);
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if ((CNT_W+1)'(1) << i >= (CNT_W+1)'(cnt)) o = ORD_W'(i);
    end
    return o;
  endfunction

  // largest aligned block at addr that fits in rem pages
  function automatic logic [ORD_W-1:0] add_order(input logic [LINK_W-1:0] addr,
                                                 input logic [CNT_W-1:0] rem);
    logic [ORD_W-1:0] fl;
    logic [ORD_W-1:0] tz;
    fl = '0;
    tz = ORD_W'(TOP_ORDER);
    for (int i = 0; i <= TOP_ORDER; i++) begin
      if (rem[i]) fl = ORD_W'(i);
    end
    for (int i = TOP_ORDER - 1; i >= 0; i--) begin
      if (addr[i]) tz = ORD_W'(i);
    end
    return (fl < tz) ? fl : tz;
  endfunction

endpackage

>>> rtl/core/buddy_page_allocator_top.sv
// top level of the buddy page allocator
// depends on bpa_pkg, bpa_ctrl and bpa_dp
//
// command channel: an item (op, base_page, page_count) is taken at a rising
// edge with start high and busy low. busy stays high until the item's
// result has been produced.
// result channel: done is high for exactly one cycle with status,
// block_page, block_order and free_count; the receiver cannot stall, so
// the result must be captured in that cycle.
// a bad request or an allocate with no block finishes without touching the
// lists; a double free is caught after a read of the page's state. an add
// inserts one aligned block at a time, an allocate makes at most sixteen
// splits and a free at most sixteen merges.
// the page-state memories each have one read and one write port, and every
// list update takes a read followed by writes. one item is worked on at a
// time.
// after reset the block clears the page states, one page a cycle, and busy
// stays high until every page is cleared and the first item can be
// accepted.
module buddy_page_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  logic [bpa_pkg::PAGE_W-1:0] base_page,
  input  logic [bpa_pkg::CNT_W-1:0]  page_count,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [bpa_pkg::PAGE_W-1:0] block_page,
  output logic [bpa_pkg::ORD_W-1:0]  block_order,
  output logic [bpa_pkg::FREE_W-1:0] free_count
);

  bpa_pkg::cmd_t  cmd;
  bpa_pkg::stat_t st;

  // state machine: steps through list inserts, unlinks, splits and merges
  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // memories, list heads and tails, free total and result registers
  bpa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .base_page   (base_page),
    .page_count  (page_count),
    .st          (st),
    .done        (done),
    .status      (status),
    .block_page  (block_page),
    .block_order (block_order),
    .free_count  (free_count)
  );

  // a result is never shown twice in a row
  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted item keeps the block busy
  a_busy_after_start : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an item was accepted");

  // failed requests report no block
  a_err_no_block : assert property (@(posedge clk) disable iff (rst)
    (done && status != bpa_pkg::ST_OK) |-> (block_page == '0 && block_order == '0))
    else $error("error result carries a block");

  // no result while idle without a request
  a_done_needs_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in work");

endmodule

>>> rtl/core/bpa_ctrl.sv
// sequencing state machine of the buddy page allocator
// depends on bpa_pkg
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bpa_pkg::stat_t st,
  output logic           busy,
  output bpa_pkg::cmd_t  cmd
);

  bpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bpa_pkg::S_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::S_CLEAR:    if (st.clr_done) state_next = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE:     if (start) state_next = bpa_pkg::S_DISP;
      bpa_pkg::S_DISP: begin
        if (st.load_err) state_next = bpa_pkg::S_FIN_BAD;
        else if (st.op == bpa_pkg::OP_ADD) state_next = bpa_pkg::S_ADD_SET;
        else if (st.op == bpa_pkg::OP_ALLOC)
          state_next = (st.too_big || !st.avail) ? bpa_pkg::S_FIN_NOBLK : bpa_pkg::S_A_SET;
        else state_next = bpa_pkg::S_F_SET;
      end
      bpa_pkg::S_ADD_SET:  state_next = bpa_pkg::S_I_RD;
      bpa_pkg::S_ADD_STEP: state_next = st.add_last ? bpa_pkg::S_FIN_OK : bpa_pkg::S_ADD_SET;
      bpa_pkg::S_A_SET:    state_next = bpa_pkg::S_U_RD;
      bpa_pkg::S_U_RD:     state_next = bpa_pkg::S_U_DO;
      bpa_pkg::S_U_DO:     state_next = bpa_pkg::S_A_SPLIT;
      bpa_pkg::S_A_SPLIT:  state_next = st.split_more ? bpa_pkg::S_I_RD : bpa_pkg::S_FIN_OK;
      bpa_pkg::S_F_SET:    state_next = bpa_pkg::S_F_RD;
      bpa_pkg::S_F_RD:     state_next = bpa_pkg::S_F_CHK;
      bpa_pkg::S_F_CHK:    state_next = st.rd_head ? bpa_pkg::S_FIN_BAD : bpa_pkg::S_F_LOOP;
      bpa_pkg::S_F_LOOP:   state_next = st.below_top ? bpa_pkg::S_F_BRD : bpa_pkg::S_I_RD;
      bpa_pkg::S_F_BRD:    state_next = bpa_pkg::S_F_BCHK;
      bpa_pkg::S_F_BCHK:   state_next = st.bud_match ? bpa_pkg::S_F_LOOP : bpa_pkg::S_I_RD;
      bpa_pkg::S_I_RD:     state_next = bpa_pkg::S_I_CHK;
      bpa_pkg::S_I_CHK:    state_next = bpa_pkg::S_I_WR;
      bpa_pkg::S_I_WR:     state_next = bpa_pkg::S_I_LNK;
      bpa_pkg::S_I_LNK: begin
        if (st.op == bpa_pkg::OP_ADD) state_next = bpa_pkg::S_ADD_STEP;
        else if (st.op == bpa_pkg::OP_ALLOC) state_next = bpa_pkg::S_A_SPLIT;
        else state_next = bpa_pkg::S_FIN_OK;
      end
      bpa_pkg::S_FIN_OK, bpa_pkg::S_FIN_NOBLK, bpa_pkg::S_FIN_BAD:
        state_next = bpa_pkg::S_IDLE;
      default: state_next = bpa_pkg::S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd.code = bpa_pkg::CMD_NOP;
    cmd.res  = bpa_pkg::ST_OK;
    unique case (state)
      bpa_pkg::S_CLEAR:    cmd.code = bpa_pkg::CMD_CLR;
      bpa_pkg::S_IDLE:     if (start) cmd.code = bpa_pkg::CMD_LOAD;
      bpa_pkg::S_DISP:     cmd.code = bpa_pkg::CMD_NOP;
      bpa_pkg::S_ADD_SET:  cmd.code = bpa_pkg::CMD_ADD_SETUP;
      bpa_pkg::S_ADD_STEP: cmd.code = bpa_pkg::CMD_ADD_STEP;
      bpa_pkg::S_A_SET:    cmd.code = bpa_pkg::CMD_ALLOC_SETUP;
      bpa_pkg::S_U_RD, bpa_pkg::S_F_RD, bpa_pkg::S_F_BRD, bpa_pkg::S_I_RD:
        cmd.code = bpa_pkg::CMD_RD;
      bpa_pkg::S_U_DO, bpa_pkg::S_I_CHK: cmd.code = bpa_pkg::CMD_UNL;
      bpa_pkg::S_A_SPLIT:  if (st.split_more) cmd.code = bpa_pkg::CMD_SPLIT;
      bpa_pkg::S_F_SET:    cmd.code = bpa_pkg::CMD_FREE_SETUP;
      bpa_pkg::S_F_CHK:    cmd.code = bpa_pkg::CMD_NOP;
      bpa_pkg::S_F_LOOP:
        cmd.code = st.below_top ? bpa_pkg::CMD_BUD : bpa_pkg::CMD_FREE_FIN;
      bpa_pkg::S_F_BCHK:
        cmd.code = st.bud_match ? bpa_pkg::CMD_MERGE : bpa_pkg::CMD_FREE_FIN;
      bpa_pkg::S_I_WR:     cmd.code = bpa_pkg::CMD_INS_WR;
      bpa_pkg::S_I_LNK:    cmd.code = bpa_pkg::CMD_INS_LNK;
      bpa_pkg::S_FIN_OK:   cmd.code = bpa_pkg::CMD_FIN;
      bpa_pkg::S_FIN_NOBLK: begin
        cmd.code = bpa_pkg::CMD_FIN;
        cmd.res  = bpa_pkg::ST_NOBLK;
      end
      bpa_pkg::S_FIN_BAD: begin
        cmd.code = bpa_pkg::CMD_FIN;
        cmd.res  = bpa_pkg::ST_BAD;
      end
      default: cmd.code = bpa_pkg::CMD_NOP;
    endcase
  end

  assign busy = (state != bpa_pkg::S_IDLE);

endmodule

>>> rtl/core/bpa_dp.sv
// datapath of the buddy page allocator: page memories, list heads and tails
// depends on bpa_pkg
module bpa_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  bpa_pkg::cmd_t                    cmd,
  input  logic [1:0]                       op,
  input  logic [bpa_pkg::PAGE_W-1:0]       base_page,
  input  logic [bpa_pkg::CNT_W-1:0]        page_count,
  output bpa_pkg::stat_t                   st,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [bpa_pkg::PAGE_W-1:0]       block_page,
  output logic [bpa_pkg::ORD_W-1:0]        block_order,
  output logic [bpa_pkg::FREE_W-1:0]       free_count
);

  logic [bpa_pkg::INFO_W-1:0] info_mem [bpa_pkg::NUM_PAGES];
  logic [bpa_pkg::LINK_W-1:0] next_mem [bpa_pkg::NUM_PAGES];
  logic [bpa_pkg::LINK_W-1:0] prev_mem [bpa_pkg::NUM_PAGES];

  logic [bpa_pkg::LINK_W-1:0] list_head [bpa_pkg::NLIST];
  logic [bpa_pkg::LINK_W-1:0] list_tail [bpa_pkg::NLIST];
  logic [bpa_pkg::FREE_W-1:0] total;

  logic [bpa_pkg::PAGE_W-1:0] clr_cnt;
  logic [1:0]                 op_r;
  logic [bpa_pkg::LINK_W-1:0] addr;
  logic [bpa_pkg::CNT_W-1:0]  rem;
  logic [bpa_pkg::ORD_W-1:0]  ord;
  logic [bpa_pkg::ORD_W-1:0]  cur;
  logic [bpa_pkg::PAGE_W-1:0] blk;
  logic [bpa_pkg::LINK_W-1:0] p;
  logic [bpa_pkg::ORD_W-1:0]  po;

  logic [bpa_pkg::INFO_W-1:0] rd_info;
  logic [bpa_pkg::LINK_W-1:0] rd_next;
  logic [bpa_pkg::LINK_W-1:0] rd_prev;

  // write ports
  logic                       info_we, next_we, prev_we;
  logic [bpa_pkg::PAGE_W-1:0] info_wa, next_wa, prev_wa;
  logic [bpa_pkg::INFO_W-1:0] info_wd;
  logic [bpa_pkg::LINK_W-1:0] next_wd, prev_wd;

  logic [bpa_pkg::ORD_W-1:0]  rd_ord;
  logic [bpa_pkg::LIST_W-1:0] rd_li, po_li, c_li;
  logic [bpa_pkg::ORD_W-1:0]  c_found;
  logic                       found;
  logic [bpa_pkg::ORD_W-1:0]  a_ord;
  logic [bpa_pkg::CNT_W-1:0]  po_pow;
  logic [bpa_pkg::CNT_W:0]    ord_pow;
  logic [bpa_pkg::LINK_W-1:0] tail_po;
  logic [bpa_pkg::ORD_W-1:0]  cur_dec;
  logic [bpa_pkg::LINK_W-1:0] bud;
  logic                       unl_act;

  assign rd_ord  = rd_info[bpa_pkg::ORD_W-1:0];
  assign rd_li   = rd_ord[bpa_pkg::LIST_W-1:0];
  assign po_li   = po[bpa_pkg::LIST_W-1:0];
  assign c_li    = c_found[bpa_pkg::LIST_W-1:0];
  assign a_ord   = bpa_pkg::add_order(addr, rem);
  assign po_pow  = bpa_pkg::CNT_W'(1) << po;
  assign ord_pow = (bpa_pkg::CNT_W+1)'(1) << ord;
  assign tail_po = list_tail[po_li];
  assign cur_dec = cur - bpa_pkg::ORD_W'(1);
  assign bud     = {1'b0, blk} ^ bpa_pkg::LINK_W'(po_pow);
  assign unl_act = rd_info[bpa_pkg::ORD_W] && (rd_ord <= bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));

  // first non-empty list at or above the requested order
  always_comb begin
    c_found = '0;
    found   = 1'b0;
    for (int i = bpa_pkg::TOP_ORDER; i >= 0; i--) begin
      if (bpa_pkg::ORD_W'(i) >= ord && list_head[i] != bpa_pkg::LINK_NONE) begin
        c_found = bpa_pkg::ORD_W'(i);
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    logic bad;
    bad = (op_r == bpa_pkg::OP_UNKNOWN) || (rem == '0);
    case (op_r)
      bpa_pkg::OP_ADD:
        bad = bad || ((bpa_pkg::CNT_W+1)'(addr) + (bpa_pkg::CNT_W+1)'(rem) >
                      (bpa_pkg::CNT_W+1)'(bpa_pkg::NUM_PAGES));
      bpa_pkg::OP_FREE:
        bad = bad || (ord > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)) ||
              (((bpa_pkg::CNT_W+1)'(addr) & (ord_pow - (bpa_pkg::CNT_W+1)'(1))) != '0) ||
              ((bpa_pkg::CNT_W+1)'(addr) + ord_pow >
               (bpa_pkg::CNT_W+1)'(bpa_pkg::NUM_PAGES));
      default: ;
    endcase
    st.load_err   = bad;
    st.clr_done   = (clr_cnt == bpa_pkg::PAGE_W'(bpa_pkg::NUM_PAGES - 1));
    st.op         = op_r;
    st.too_big    = (ord > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
    st.avail      = found;
    st.rd_head    = rd_info[bpa_pkg::ORD_W];
    st.bud_match  = (p < bpa_pkg::LINK_NONE) &&
                    (rd_info == {1'b1, po});
    st.below_top  = (po < bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
    st.add_last   = (rem == po_pow);
    st.split_more = (cur > ord);
  end

  // memory write selection
  always_comb begin
    info_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
    info_wa = p[bpa_pkg::PAGE_W-1:0];
    next_wa = p[bpa_pkg::PAGE_W-1:0];
    prev_wa = p[bpa_pkg::PAGE_W-1:0];
    info_wd = '0;
    next_wd = bpa_pkg::LINK_NONE;
    prev_wd = tail_po;
    case (cmd.code)
      bpa_pkg::CMD_CLR: begin
        info_we = 1'b1;
        info_wa = clr_cnt;
      end
      bpa_pkg::CMD_UNL, bpa_pkg::CMD_MERGE: begin
        if (rd_info[bpa_pkg::ORD_W]) info_we = 1'b1;
        if (unl_act && rd_prev < bpa_pkg::LINK_NONE) begin
          next_we = 1'b1;
          next_wa = rd_prev[bpa_pkg::PAGE_W-1:0];
          next_wd = rd_next;
        end
        if (unl_act && rd_next < bpa_pkg::LINK_NONE) begin
          prev_we = 1'b1;
          prev_wa = rd_next[bpa_pkg::PAGE_W-1:0];
          prev_wd = rd_prev;
        end
      end
      bpa_pkg::CMD_INS_WR: begin
        info_we = 1'b1;
        info_wd = {1'b1, po};
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      bpa_pkg::CMD_INS_LNK: begin
        if (tail_po < bpa_pkg::LINK_NONE) begin
          next_we = 1'b1;
          next_wa = tail_po[bpa_pkg::PAGE_W-1:0];
          next_wd = p;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd.code == bpa_pkg::CMD_RD) begin
      rd_info <= info_mem[p[bpa_pkg::PAGE_W-1:0]];
      rd_next <= next_mem[p[bpa_pkg::PAGE_W-1:0]];
      rd_prev <= prev_mem[p[bpa_pkg::PAGE_W-1:0]];
    end
  end

  // list heads, tails and the free total
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bpa_pkg::NLIST; i++) begin
        list_head[i] <= bpa_pkg::LINK_NONE;
        list_tail[i] <= bpa_pkg::LINK_NONE;
      end
      total <= '0;
    end else begin
      case (cmd.code)
        bpa_pkg::CMD_UNL, bpa_pkg::CMD_MERGE: begin
          if (unl_act) begin
            if (rd_prev >= bpa_pkg::LINK_NONE) list_head[rd_li] <= rd_next;
            if (rd_next >= bpa_pkg::LINK_NONE) list_tail[rd_li] <= rd_prev;
            total <= total - (bpa_pkg::FREE_W'(1) << rd_ord);
          end
        end
        bpa_pkg::CMD_INS_LNK: begin
          if (tail_po >= bpa_pkg::LINK_NONE) list_head[po_li] <= p;
          list_tail[po_li] <= p;
          total <= total + bpa_pkg::FREE_W'(po_pow);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= (cmd.code == bpa_pkg::CMD_FIN);
      if (cmd.code == bpa_pkg::CMD_CLR) clr_cnt <= clr_cnt + bpa_pkg::PAGE_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      bpa_pkg::CMD_LOAD: begin
        op_r <= op;
        addr <= {1'b0, base_page};
        rem  <= page_count;
        ord  <= bpa_pkg::order_for(page_count);
      end
      bpa_pkg::CMD_ADD_SETUP: begin
        p  <= addr;
        po <= a_ord;
      end
      bpa_pkg::CMD_ADD_STEP: begin
        addr <= addr + bpa_pkg::LINK_W'(po_pow);
        rem  <= rem - po_pow;
      end
      bpa_pkg::CMD_ALLOC_SETUP: begin
        cur <= c_found;
        p   <= list_head[c_li];
        blk <= list_head[c_li][bpa_pkg::PAGE_W-1:0];
      end
      bpa_pkg::CMD_SPLIT: begin
        cur <= cur_dec;
        po  <= cur_dec;
        p   <= {1'b0, blk} + (bpa_pkg::LINK_W'(1) << cur_dec);
      end
      bpa_pkg::CMD_FREE_SETUP: begin
        p   <= addr;
        blk <= addr[bpa_pkg::PAGE_W-1:0];
        po  <= ord;
      end
      bpa_pkg::CMD_BUD: p <= bud;
      bpa_pkg::CMD_MERGE: begin
        if (p[bpa_pkg::PAGE_W-1:0] < blk) blk <= p[bpa_pkg::PAGE_W-1:0];
        po <= po + bpa_pkg::ORD_W'(1);
      end
      bpa_pkg::CMD_FREE_FIN: p <= {1'b0, blk};
      bpa_pkg::CMD_FIN: begin
        status      <= cmd.res;
        free_count  <= total;
        block_page  <= '0;
        block_order <= '0;
        if (cmd.res == bpa_pkg::ST_OK && op_r == bpa_pkg::OP_ALLOC) begin
          block_page  <= blk;
          block_order <= ord;
        end else if (cmd.res == bpa_pkg::ST_OK && op_r == bpa_pkg::OP_FREE) begin
          block_page  <= blk;
          block_order <= po;
        end
      end
      default: ;
    endcase
  end

endmodule
